@@ rtl/core/lkc_pkg.sv @@
`default_nettype none

package lkc_pkg;

    // Cache geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Limit register width is fixed by the register map
    localparam int MAX_W    = 5;
    localparam int LIM_W    = (CNT_W > MAX_W) ? CNT_W : MAX_W;
    localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = MAX_W'(16);

    localparam int WORD_W   = 64;

    // Request codes
    localparam logic [1:0] REQ_LOOKUP     = 2'd0;
    localparam logic [1:0] REQ_STORE      = 2'd1;
    localparam logic [1:0] REQ_INVALIDATE = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] key_word0;
        logic [WORD_W-1:0] key_word1;
        logic [WORD_W-1:0] key_word2;
        logic [WORD_W-1:0] key_word3;
        logic [WORD_W-1:0] value_handle;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] value_out;
        logic              evicted;
        logic [WORD_W-1:0] generation;
    } rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/lru_keyed_cache_top.sv @@
`default_nettype none

// Fully associative LRU cache of lkc_pkg::CAPACITY entries keyed by a 256-bit
// digest. The block takes one item in every cycle (busy stays low) and answers
// each item exactly once: the result is strobed on done for a single cycle.
// The item is registered first; the parallel tag compare and rank update then
// run on the registered item, and the result is registered together with done.
// Results come out in request order and cannot be held off, so the receiver
// must take each one in the cycle it is shown. Write max_entries only while
// no item is in flight.
module lru_keyed_cache_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire lkc_pkg::req_t             req,
    output logic                           done,
    output lkc_pkg::rsp_t                  result,
    input  wire logic                      cfg_we,
    input  wire logic [lkc_pkg::MAX_W-1:0] cfg_wdata
);

    localparam int CAP = lkc_pkg::CAPACITY;
    localparam int IW  = lkc_pkg::IDX_W;
    localparam int LW  = lkc_pkg::LIM_W;
    localparam int WW  = lkc_pkg::WORD_W;

    // Control state
    logic                      in_valid_reg;
    logic                      done_reg;
    logic [CAP-1:0]            valid_reg;
    logic [CAP-1:0]            valid_next;
    logic [WW-1:0]             gen_reg;
    logic [WW-1:0]             gen_next;
    logic [lkc_pkg::MAX_W-1:0] max_entries_reg;

    // Payload state
    lkc_pkg::req_t             req_reg;
    lkc_pkg::rsp_t             rsp_reg;
    lkc_pkg::rsp_t             rsp_next;
    logic [WW-1:0]             key0_reg [CAP];
    logic [WW-1:0]             key1_reg [CAP];
    logic [WW-1:0]             key2_reg [CAP];
    logic [WW-1:0]             key3_reg [CAP];
    logic [WW-1:0]             value_reg [CAP];
    logic [IW-1:0]             rank_reg [CAP];
    logic [IW-1:0]             rank_next [CAP];

    // Compare and update signals
    logic [CAP-1:0]            match;
    logic                      hit_any;
    logic [IW-1:0]             hit_idx;
    logic [IW-1:0]             hit_rank;
    logic [LW-1:0]             limit;
    logic [CAP-1:0]            evict;
    logic [CAP-1:0]            kept;
    logic                      free_found;
    logic [IW-1:0]             free_idx;
    logic                      key_we;
    logic                      value_we;
    logic [IW-1:0]             wr_idx;
    logic                      is_lookup;
    logic                      is_store;
    logic                      is_inval;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = rsp_reg;

    // Decode the registered item
    assign is_lookup = in_valid_reg && (req_reg.req_type == lkc_pkg::REQ_LOOKUP);
    assign is_store  = in_valid_reg && (req_reg.req_type == lkc_pkg::REQ_STORE);
    assign is_inval  = in_valid_reg && (req_reg.req_type == lkc_pkg::REQ_INVALIDATE);

    // Clamp the limit to the capacity
    always_comb
    begin
        if (LW'(max_entries_reg) > LW'(CAP))
            limit = LW'(CAP);
        else
            limit = LW'(max_entries_reg);
    end

    // Compare the key against every entry in parallel
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            match[i] = valid_reg[i] &&
                       (key0_reg[i] == req_reg.key_word0) &&
                       (key1_reg[i] == req_reg.key_word1) &&
                       (key2_reg[i] == req_reg.key_word2) &&
                       (key3_reg[i] == req_reg.key_word3);
        end
    end

    // Encode the first matching entry
    always_comb
    begin
        hit_any = |match;
        hit_idx = '0;
        for (int i = CAP - 1; i >= 0; i--)
        begin
            if (match[i])
                hit_idx = IW'(i);
        end
        hit_rank = rank_reg[hit_idx];
    end

    // Mark entries that age out on an insert
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            evict[i] = valid_reg[i] && ((LW'(rank_reg[i]) + LW'(1)) >= limit);
        end
        kept = valid_reg & ~evict;
    end

    // Find the first empty slot after eviction
    always_comb
    begin
        free_found = ~&kept;
        free_idx   = '0;
        for (int i = CAP - 1; i >= 0; i--)
        begin
            if (!kept[i])
                free_idx = IW'(i);
        end
    end

    // Work out next state and the result
    always_comb
    begin
        valid_next = valid_reg;
        gen_next   = gen_reg;
        key_we     = 1'b0;
        value_we   = 1'b0;
        wr_idx     = hit_idx;
        rsp_next   = '0;
        for (int i = 0; i < CAP; i++)
        begin
            rank_next[i] = rank_reg[i];
        end

        if (is_lookup && hit_any)
        begin
            rsp_next.hit       = 1'b1;
            rsp_next.value_out = value_reg[hit_idx];
            for (int i = 0; i < CAP; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    rank_next[i] = rank_reg[i] + IW'(1);
            end
            rank_next[hit_idx] = '0;
        end
        else if (is_store && (limit != '0))
        begin
            if (hit_any)
            begin
                rsp_next.hit = 1'b1;
                value_we     = 1'b1;
                for (int i = 0; i < CAP; i++)
                begin
                    if (valid_reg[i] && (rank_reg[i] < hit_rank))
                        rank_next[i] = rank_reg[i] + IW'(1);
                end
                rank_next[hit_idx] = '0;
            end
            else
            begin
                rsp_next.evicted = |evict;
                valid_next       = kept;
                for (int i = 0; i < CAP; i++)
                begin
                    if (kept[i])
                        rank_next[i] = rank_reg[i] + IW'(1);
                end
                if (free_found)
                begin
                    valid_next[free_idx] = 1'b1;
                    rank_next[free_idx]  = '0;
                    key_we               = 1'b1;
                    value_we             = 1'b1;
                    wr_idx               = free_idx;
                end
            end
        end
        else if (is_inval)
        begin
            valid_next = '0;
            gen_next   = gen_reg + WW'(1);
        end

        rsp_next.generation = gen_next;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            done_reg        <= 1'b0;
            valid_reg       <= '0;
            gen_reg         <= '0;
            max_entries_reg <= lkc_pkg::MAX_ENTRIES_RST;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
            valid_reg    <= valid_next;
            gen_reg      <= gen_next;
            if (cfg_we)
                max_entries_reg <= cfg_wdata;
        end
    end

    // Capture the item, the result and the entry payload
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= req;
        if (in_valid_reg)
            rsp_reg <= rsp_next;
        for (int i = 0; i < CAP; i++)
        begin
            rank_reg[i] <= rank_next[i];
        end
        if (key_we)
        begin
            key0_reg[wr_idx] <= req_reg.key_word0;
            key1_reg[wr_idx] <= req_reg.key_word1;
            key2_reg[wr_idx] <= req_reg.key_word2;
            key3_reg[wr_idx] <= req_reg.key_word3;
        end
        if (value_we)
            value_reg[wr_idx] <= req_reg.value_handle;
    end

`ifndef ASSERT_OFF
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done)
        else $error("registered item produced no result");

    a_inval_clears: assert property (@(posedge clk) disable iff (!rst_n)
        is_inval |=> (valid_reg == '0))
        else $error("invalidate left entries valid");

    a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
        is_inval |=> (gen_reg == $past(gen_reg) + WW'(1)))
        else $error("generation did not advance on invalidate");

    a_evict_on_store: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.evicted) |-> $past(is_store))
        else $error("eviction reported for a non-store item");

    a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.value_out == '0))
        else $error("value returned without a hit");
`endif

endmodule

`default_nettype wire

@@ bench/tb_lru_keyed_cache_top.sv @@
`default_nettype none

module tb_lru_keyed_cache_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int PHASES = 10;
    localparam int RANDOM_PER_PHASE = 134;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT = 10;

    typedef logic [4*lkc_pkg::WORD_W-1:0] key_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    lkc_pkg::req_t req = '0;
    logic done;
    lkc_pkg::rsp_t result;
    logic cfg_we = 1'b0;
    logic [lkc_pkg::MAX_W-1:0] cfg_wdata = '0;

    // Predicted cache contents
    logic                       cache_valid [lkc_pkg::CAPACITY];
    key_t                       cache_key   [lkc_pkg::CAPACITY];
    logic [lkc_pkg::WORD_W-1:0] cache_value [lkc_pkg::CAPACITY];
    int                         cache_rank  [lkc_pkg::CAPACITY];
    logic [lkc_pkg::WORD_W-1:0] cache_gen;
    logic [lkc_pkg::MAX_W-1:0]  cache_limit;

    lkc_pkg::req_t pending_req [$];
    lkc_pkg::rsp_t awaited_rsp [$];
    key_t key_pool [$];
    lkc_pkg::rsp_t want;
    lkc_pkg::rsp_t pred;

    int gap_left = 0;
    bit steady_feed = 1'b0;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int n_items = 0;
    int n_hits = 0;
    int n_evictions = 0;
    int n_invalidates = 0;
    int n_writes = 0;

    lru_keyed_cache_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic logic [lkc_pkg::WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic lkc_pkg::req_t make_req(input logic [1:0] op, input key_t k,
                                               input logic [lkc_pkg::WORD_W-1:0] v);
        lkc_pkg::req_t r;
        r.req_type     = op;
        r.key_word0    = k[0*lkc_pkg::WORD_W +: lkc_pkg::WORD_W];
        r.key_word1    = k[1*lkc_pkg::WORD_W +: lkc_pkg::WORD_W];
        r.key_word2    = k[2*lkc_pkg::WORD_W +: lkc_pkg::WORD_W];
        r.key_word3    = k[3*lkc_pkg::WORD_W +: lkc_pkg::WORD_W];
        r.value_handle = v;
        return r;
    endfunction

    function automatic int find_entry(input key_t k);
        for (int i = 0; i < lkc_pkg::CAPACITY; i++)
            if (cache_valid[i] && cache_key[i] == k)
                return i;
        return -1;
    endfunction

    // Move an entry to the front; younger entries age by one
    function automatic void promote(input int idx);
        int r;
        r = cache_rank[idx];
        for (int i = 0; i < lkc_pkg::CAPACITY; i++)
            if (cache_valid[i] && cache_rank[i] < r)
                cache_rank[i]++;
        cache_rank[idx] = 0;
    endfunction

    // Apply one request to the predicted cache and return its answer
    function automatic lkc_pkg::rsp_t cache_access(input lkc_pkg::req_t r);
        lkc_pkg::rsp_t o;
        key_t k;
        int idx;
        int lim;
        o = '0;
        k = {r.key_word3, r.key_word2, r.key_word1, r.key_word0};
        case (r.req_type)
            lkc_pkg::REQ_LOOKUP:
            begin
                idx = find_entry(k);
                if (idx >= 0)
                begin
                    o.hit = 1'b1;
                    o.value_out = cache_value[idx];
                    promote(idx);
                end
            end
            lkc_pkg::REQ_STORE:
            begin
                lim = (int'(cache_limit) > lkc_pkg::CAPACITY) ? lkc_pkg::CAPACITY
                                                             : int'(cache_limit);
                if (lim != 0)
                begin
                    idx = find_entry(k);
                    if (idx >= 0)
                    begin
                        o.hit = 1'b1;
                        cache_value[idx] = r.value_handle;
                        promote(idx);
                    end
                    else
                    begin
                        // drop entries that would fall past the limit
                        for (int i = 0; i < lkc_pkg::CAPACITY; i++)
                            if (cache_valid[i] && cache_rank[i] + 1 >= lim)
                            begin
                                cache_valid[i] = 1'b0;
                                o.evicted = 1'b1;
                            end
                        idx = -1;
                        for (int i = 0; i < lkc_pkg::CAPACITY; i++)
                            if (cache_valid[i])
                                cache_rank[i]++;
                            else if (idx < 0)
                                idx = i;
                        if (idx >= 0)
                        begin
                            cache_valid[idx] = 1'b1;
                            cache_key[idx]   = k;
                            cache_value[idx] = r.value_handle;
                            cache_rank[idx]  = 0;
                        end
                    end
                end
            end
            lkc_pkg::REQ_INVALIDATE:
            begin
                for (int i = 0; i < lkc_pkg::CAPACITY; i++)
                    cache_valid[i] = 1'b0;
                cache_gen++;
            end
            default: ;
        endcase
        o.generation = cache_gen;
        return o;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (steady_feed || p < 55)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly pool keys so entries get hit, aged and evicted
    function automatic lkc_pkg::req_t random_item();
        key_t k;
        logic [1:0] op;
        int p;
        p = $urandom_range(199);
        if (p < 90)
            op = lkc_pkg::REQ_LOOKUP;
        else if (p < 192)
            op = lkc_pkg::REQ_STORE;
        else if (p < 196)
            op = lkc_pkg::REQ_INVALIDATE;
        else
            op = REQ_UNUSED;
        p = $urandom_range(99);
        if (p < 80)
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        else if (p < 90)
        begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
            k[$urandom_range(4*lkc_pkg::WORD_W - 1)] ^= 1'b1;
        end
        else
            k = {rand_word(), rand_word(), rand_word(), rand_word()};
        return make_req(op, k, rand_word());
    endfunction

    function automatic int limit_for_phase(input int ph);
        case (ph)
            1: return 1;
            2: return 0;
            3: return 31;
            4: return 3;
            5: return 17;
            6: return 2;
            7: return 7;
            8: return 16;
            default: return 5;
        endcase
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] %s", $time, msg);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_req.size() != 0 || start || awaited_rsp.size() != 0);
    endtask

    task automatic write_limit(input int v);
        repeat (3) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[lkc_pkg::MAX_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cache_limit = v[lkc_pkg::MAX_W-1:0];
        n_writes++;
    endtask

    task automatic refill_pool();
        int n;
        n = $urandom_range(2, 24);
        key_pool.delete();
        repeat (n)
            key_pool.push_back({rand_word(), rand_word(), rand_word(), rand_word()});
    endtask

    // Driver: predict on accept, then present the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                pred = cache_access(req);
                awaited_rsp.push_back(pred);
                n_items++;
                n_hits += pred.hit;
                n_evictions += pred.evicted;
                if (req.req_type == lkc_pkg::REQ_INVALIDATE)
                    n_invalidates++;
            end
            if (start && busy)
                ;
            else if (gap_left != 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_req.size() != 0)
            begin
                req <= pending_req.pop_front();
                start <= 1'b1;
                gap_left <= pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each strobed result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, awaited_rsp.size());
                $display("end of test: mismatches");
                $finish;
            end
            else
            begin
                quiet_cycles <= ((start && !busy) || done) ? 0 : quiet_cycles + 1;
                if (done)
                begin
                    if (awaited_rsp.size() == 0)
                        log_mismatch($sformatf({"result with no request pending: ",
                            "hit=%0b value=%h evicted=%0b gen=%0d"}, result.hit,
                            result.value_out, result.evicted, result.generation));
                    else
                    begin
                        want = awaited_rsp.pop_front();
                        if (result.hit !== want.hit || result.value_out !== want.value_out ||
                            result.evicted !== want.evicted ||
                            result.generation !== want.generation)
                            log_mismatch($sformatf({"expected hit=%0b value=%h evicted=%0b ",
                                "gen=%0d, got hit=%0b value=%h evicted=%0b gen=%0d"},
                                want.hit, want.value_out, want.evicted, want.generation,
                                result.hit, result.value_out, result.evicted,
                                result.generation));
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed items, then random phases over limit settings
    initial
    begin
        key_t k;
        for (int i = 0; i < lkc_pkg::CAPACITY; i++)
        begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_value[i] = '0;
            cache_rank[i]  = 0;
        end
        cache_gen = '0;
        cache_limit = lkc_pkg::MAX_ENTRIES_RST;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty miss, extreme keys and values, near misses per word
        pending_req.push_back(make_req(lkc_pkg::REQ_LOOKUP, '1, '0));
        pending_req.push_back(make_req(lkc_pkg::REQ_STORE, '1, '1));
        pending_req.push_back(make_req(lkc_pkg::REQ_STORE, '0, '0));
        pending_req.push_back(make_req(lkc_pkg::REQ_LOOKUP, '1, '0));
        pending_req.push_back(make_req(lkc_pkg::REQ_LOOKUP, '0, '1));
        for (int w = 0; w < 4; w++)
        begin
            k = '1;
            k[w*lkc_pkg::WORD_W +: lkc_pkg::WORD_W] = '0;
            pending_req.push_back(make_req(lkc_pkg::REQ_LOOKUP, k, '0));
        end
        pending_req.push_back(make_req(lkc_pkg::REQ_STORE, '1, 64'h5a5a_a5a5_0f0f_f0f0));
        pending_req.push_back(make_req(lkc_pkg::REQ_LOOKUP, '1, '1));
        pending_req.push_back(make_req(REQ_UNUSED, '1, '1));
        pending_req.push_back(make_req(lkc_pkg::REQ_LOOKUP, '0, '0));
        pending_req.push_back(make_req(lkc_pkg::REQ_INVALIDATE, '0, '1));
        pending_req.push_back(make_req(lkc_pkg::REQ_LOOKUP, '1, '0));
        pending_req.push_back(make_req(lkc_pkg::REQ_STORE, '1, rand_word()));
        pending_req.push_back(make_req(REQ_UNUSED, '0, '0));
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
                write_limit(limit_for_phase(ph));
            if (ph % 3 == 0)
                refill_pool();
            steady_feed = (ph % 3 == 1);
            if (ph == 5)
            begin
                // hold the sender until every answer is back, then resume
                repeat (RANDOM_PER_PHASE / 2)
                    pending_req.push_back(random_item());
                wait_idle();
                repeat (RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2)
                    pending_req.push_back(random_item());
            end
            else
                repeat (RANDOM_PER_PHASE)
                    pending_req.push_back(random_item());
            wait_idle();
        end

        repeat (8) @(negedge clk);
        $display("covered %0d requests across %0d limit writes (0, 1, 16 and above capacity)",
                 n_items, n_writes);
        $display("saw %0d hits, %0d evicting stores, %0d invalidates",
                 n_hits, n_evictions, n_invalidates);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
